// ===== src/plet_pkg.sv =====
// Shared constants, codes and stage word types for the piecewise linear envelope table.
// No dependencies; the design files refer to this package by scoped names, the test files import it.
package plet_pkg;

  // Largest table the block serves; frame_count saturates to it.
  localparam int MAX_FRAMES = 65536;

  localparam int POS_W      = 16;
  localparam int N_W        = 17;
  localparam int LVL_W      = 16;
  localparam int ST_W       = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = N_W;

  // Divider: quotient bits, bits retired per stage, stage count.
  localparam int Q_W        = 16;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;
  localparam int PROD_W     = 2 * Q_W;

  localparam logic [LVL_W-1:0] ONE_Q15         = LVL_W'(32768);
  localparam logic [LVL_W-1:0] DEFAULT_SUSTAIN = LVL_W'(10912);

  localparam logic [ST_W-1:0] ST_OK    = ST_W'(0);
  localparam logic [ST_W-1:0] ST_FIT   = ST_W'(1);
  localparam logic [ST_W-1:0] ST_RANGE = ST_W'(2);

  localparam logic [MODE_W-1:0] MODE_AD   = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_ADR  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_ADSR = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_ALT  = MODE_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = CFG_IDX_W'(5);

  // Configuration as the pipeline sees it (already saturated / defaulted).
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [N_W-1:0]    frames;
    logic [N_W-1:0]    attack;
    logic [N_W-1:0]    decay;
    logic [N_W-1:0]    rel_len;
    logic [LVL_W-1:0]  sustain;
  } cfg_t;

  // Word after the prep stage: position plus segment boundaries.
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [MODE_W-1:0] mode;
    logic [N_W-1:0]    frames;
    logic [N_W-1:0]    attack;
    logic [N_W-1:0]    decay;
    logic [LVL_W-1:0]  sustain;
    logic [N_W:0]      ad;
    logic [N_W+1:0]    adr;
    logic [N_W-1:0]    n_a;
    logic [N_W-1:0]    n_p;
    logic [N_W-1:0]    ad_p;
    logic [N_W-1:0]    rel_seg;
    logic [N_W-1:0]    sus_end;
  } prep_t;

  // Word after classification: level = base + mult * j / den.
  typedef struct packed {
    logic [LVL_W-1:0] mult;
    logic [N_W-1:0]   j;
    logic [N_W-1:0]   den;
    logic [LVL_W-1:0] base;
    logic [ST_W-1:0]  status;
  } term_t;

  // Divider word: partial remainder, unconsumed dividend bits, quotient so far.
  typedef struct packed {
    logic [N_W-1:0]   rem;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   q;
    logic [N_W-1:0]   den;
    logic [LVL_W-1:0] base;
    logic [ST_W-1:0]  status;
  } div_t;

endpackage

// ===== src/plet_if.sv =====
// Handshake channel interfaces: request, result and configuration write.
// Depends on plet_pkg for field widths.
interface plet_req_if;
  logic                        valid;
  logic                        ready;
  logic [plet_pkg::POS_W-1:0]  position;
  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface plet_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [plet_pkg::LVL_W-1:0]  level;
  logic [plet_pkg::ST_W-1:0]   status;
  modport source (output valid, output level, output status, input ready);
  modport sink   (input valid, input level, input status, output ready);
endinterface

interface plet_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [plet_pkg::CFG_IDX_W-1:0]   index;
  logic [plet_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/plet_prep.sv =====
// First pipeline stage: capture the position and precompute segment sums and differences.
// Depends on plet_pkg.
module plet_prep (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [plet_pkg::POS_W-1:0] in_pos,
  input  plet_pkg::cfg_t             cfg,
  output logic                       out_valid,
  input  logic                       out_ready,
  output plet_pkg::prep_t            out_data
);

  plet_pkg::prep_t data_next;

  always_comb begin
    logic [plet_pkg::N_W:0] ad;
    ad = {1'b0, cfg.attack} + {1'b0, cfg.decay};
    data_next.pos     = in_pos;
    data_next.mode    = cfg.mode;
    data_next.frames  = cfg.frames;
    data_next.attack  = cfg.attack;
    data_next.decay   = cfg.decay;
    data_next.sustain = cfg.sustain;
    data_next.ad      = ad;
    data_next.adr     = {2'b00, cfg.attack} + {2'b00, cfg.decay} + {2'b00, cfg.rel_len};
    data_next.n_a     = cfg.frames - cfg.attack;
    data_next.n_p     = cfg.frames - {1'b0, in_pos};
    data_next.ad_p    = plet_pkg::N_W'(ad - {2'b00, in_pos});
    // Release length: remainder of the table in mode 1, the register otherwise.
    if (cfg.mode == plet_pkg::MODE_ADR) begin
      data_next.rel_seg = cfg.frames - cfg.attack - cfg.decay;
      data_next.sus_end = plet_pkg::N_W'(ad);
    end else begin
      data_next.rel_seg = cfg.rel_len;
      data_next.sus_end = cfg.frames - cfg.rel_len;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== src/plet_class.sv =====
// Second pipeline stage: check fit and range, pick the segment and its ramp terms.
// Depends on plet_pkg.
module plet_class (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  plet_pkg::prep_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output plet_pkg::term_t out_data
);

  plet_pkg::term_t data_next;

  always_comb begin
    logic fit_bad;
    logic range_bad;
    case (in_data.mode)
      plet_pkg::MODE_AD:  fit_bad = in_data.attack > in_data.frames;
      plet_pkg::MODE_ADR: fit_bad = in_data.ad >= {1'b0, in_data.frames};
      default:            fit_bad = in_data.adr >= {2'b00, in_data.frames};
    endcase
    range_bad = {1'b0, in_data.pos} >= in_data.frames;

    data_next.mult   = '0;
    data_next.j      = '0;
    data_next.den    = plet_pkg::N_W'(1);
    data_next.base   = '0;
    data_next.status = plet_pkg::ST_OK;

    if (fit_bad) begin
      data_next.status = plet_pkg::ST_FIT;
    end else if (range_bad) begin
      data_next.status = plet_pkg::ST_RANGE;
    end else if ({1'b0, in_data.pos} < in_data.attack) begin
      data_next.mult = plet_pkg::ONE_Q15;
      data_next.j    = {1'b0, in_data.pos};
      data_next.den  = in_data.attack;
    end else if (in_data.mode == plet_pkg::MODE_AD) begin
      data_next.mult = plet_pkg::ONE_Q15;
      data_next.j    = in_data.n_p;
      data_next.den  = in_data.n_a;
    end else if ({2'b00, in_data.pos} < in_data.ad) begin
      data_next.mult = plet_pkg::ONE_Q15 - in_data.sustain;
      data_next.j    = in_data.ad_p;
      data_next.den  = in_data.decay;
      data_next.base = in_data.sustain;
    end else if ({1'b0, in_data.pos} < in_data.sus_end) begin
      data_next.base = in_data.sustain;
    end else begin
      data_next.mult = in_data.sustain;
      data_next.j    = in_data.n_p;
      data_next.den  = in_data.rel_seg;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== src/plet_mul.sv =====
// Third pipeline stage: form the dividend mult * j and seed the divider word.
// Depends on plet_pkg.
module plet_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  plet_pkg::term_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output plet_pkg::div_t  out_data
);

  plet_pkg::div_t data_next;

  always_comb begin
    logic [plet_pkg::PROD_W-1:0] prod;
    prod = plet_pkg::PROD_W'({{plet_pkg::N_W{1'b0}}, in_data.mult} *
                             {{plet_pkg::LVL_W{1'b0}}, in_data.j});
    // Quotient fits Q_W bits, so the high half is already below den.
    data_next.rem    = plet_pkg::N_W'(prod[plet_pkg::PROD_W-1:plet_pkg::Q_W]);
    data_next.low    = prod[plet_pkg::Q_W-1:0];
    data_next.q      = '0;
    data_next.den    = in_data.den;
    data_next.base   = in_data.base;
    data_next.status = in_data.status;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== src/plet_div_stage.sv =====
// One restoring-divider stage: retire DIV_STEPS quotient bits per word.
// Depends on plet_pkg.
module plet_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  plet_pkg::div_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output plet_pkg::div_t out_data
);

  plet_pkg::div_t data_next;

  always_comb begin
    logic [plet_pkg::N_W:0] trial;
    data_next = in_data;
    for (int k = 0; k < plet_pkg::DIV_STEPS; k++) begin
      trial = {data_next.rem, data_next.low[plet_pkg::Q_W-1]};
      data_next.low = data_next.low << 1;
      if (trial >= {1'b0, data_next.den}) begin
        data_next.rem = plet_pkg::N_W'(trial - {1'b0, data_next.den});
        data_next.q   = {data_next.q[plet_pkg::Q_W-2:0], 1'b1};
      end else begin
        data_next.rem = trial[plet_pkg::N_W-1:0];
        data_next.q   = {data_next.q[plet_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== src/piecewise_linear_envelope_table.sv =====
// Top level of the piecewise linear envelope table: config registers, pipeline, result register.
// Depends on plet_pkg, plet_if.sv and the plet_prep/class/mul/div_stage modules.
//
//   channel  role    word                      accepted when
//   req      sink    position                  req.valid && req.ready
//   rsp      source  level, status             rsp.valid && rsp.ready
//   cfg      sink    index, data (17 bits)     cfg.valid && cfg.ready (ready is always high)
//
// One word enters per clock while no stall backs up to req.ready; a request, once taken, passes through
// prep, classify, multiply, 8 divider stages at 2 quotient bits each, then the result register.
// The 16-bit quotient of the 16x17 product by the segment length sets the divider depth.
// Reset (rst, synchronous) clears every valid bit and loads the register defaults.
// A full stage holds its word until its successor takes it; empty slots close up under a stall.
module piecewise_linear_envelope_table (
  input  logic         clk,
  input  logic         rst,
  plet_req_if.sink     req,
  plet_rsp_if.source   rsp,
  plet_cfg_if.sink     cfg
);

  // Clamp the frame count to the largest supported table.
  function automatic logic [plet_pkg::N_W-1:0] frames_sat(input logic [plet_pkg::N_W-1:0] v);
    if (32'(v) > plet_pkg::MAX_FRAMES) begin
      return plet_pkg::N_W'(plet_pkg::MAX_FRAMES);
    end
    return v;
  endfunction

  // Zero picks the default level; anything above full scale clamps to it.
  function automatic logic [plet_pkg::LVL_W-1:0] sustain_norm(
    input logic [plet_pkg::LVL_W-1:0] v
  );
    if (v == '0) begin
      return plet_pkg::DEFAULT_SUSTAIN;
    end
    if (v > plet_pkg::ONE_Q15) begin
      return plet_pkg::ONE_Q15;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers, held in their effective form.
  // ---------------------------------------------------------------------------
  plet_pkg::cfg_t env_cfg;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      env_cfg.mode    <= plet_pkg::MODE_AD;
      env_cfg.frames  <= frames_sat(plet_pkg::N_W'(65536));
      env_cfg.attack  <= '0;
      env_cfg.decay   <= '0;
      env_cfg.rel_len <= '0;
      env_cfg.sustain <= plet_pkg::DEFAULT_SUSTAIN;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        plet_pkg::CFG_MODE: begin
          // Mode 3 runs as the full attack-decay-sustain-release shape.
          if (cfg.data[plet_pkg::MODE_W-1:0] == plet_pkg::MODE_ALT) begin
            env_cfg.mode <= plet_pkg::MODE_ADSR;
          end else begin
            env_cfg.mode <= cfg.data[plet_pkg::MODE_W-1:0];
          end
        end
        plet_pkg::CFG_FRAMES:  env_cfg.frames  <= frames_sat(cfg.data);
        plet_pkg::CFG_ATTACK:  env_cfg.attack  <= cfg.data;
        plet_pkg::CFG_DECAY:   env_cfg.decay   <= cfg.data;
        plet_pkg::CFG_RELEASE: env_cfg.rel_len <= cfg.data;
        plet_pkg::CFG_SUSTAIN: env_cfg.sustain <= sustain_norm(cfg.data[plet_pkg::LVL_W-1:0]);
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Front stages: prep, classify, multiply.
  // ---------------------------------------------------------------------------
  logic            prep_valid;
  logic            prep_ready;
  plet_pkg::prep_t prep_data;
  logic            term_valid;
  logic            term_ready;
  plet_pkg::term_t term_data;

  logic [plet_pkg::DIV_STAGES:0] div_valid;
  logic [plet_pkg::DIV_STAGES:0] div_ready;
  plet_pkg::div_t                div_data [plet_pkg::DIV_STAGES+1];

  plet_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_pos    (req.position),
    .cfg       (env_cfg),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  plet_class u_class (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (term_valid),
    .out_ready (term_ready),
    .out_data  (term_data)
  );

  plet_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (term_valid),
    .in_ready  (term_ready),
    .in_data   (term_data),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_data  (div_data[0])
  );

  // ---------------------------------------------------------------------------
  // Divider chain: each stage shifts in the next dividend bits.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < plet_pkg::DIV_STAGES; g++) begin : g_div
    plet_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[g]),
      .in_ready  (div_ready[g]),
      .in_data   (div_data[g]),
      .out_valid (div_valid[g+1]),
      .out_ready (div_ready[g+1]),
      .out_data  (div_data[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register: add the segment base to the quotient.
  // Error words carry base 0 and a zero dividend, so they come out as level 0.
  // ---------------------------------------------------------------------------
  logic                       res_valid;
  logic [plet_pkg::LVL_W-1:0] res_level;
  logic [plet_pkg::ST_W-1:0]  res_status;
  logic [plet_pkg::LVL_W-1:0] level_next;

  assign level_next = div_data[plet_pkg::DIV_STAGES].base + div_data[plet_pkg::DIV_STAGES].q;
  assign div_ready[plet_pkg::DIV_STAGES] = !res_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (div_ready[plet_pkg::DIV_STAGES]) begin
      res_valid <= div_valid[plet_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (div_valid[plet_pkg::DIV_STAGES] && div_ready[plet_pkg::DIV_STAGES]) begin
      res_level  <= level_next;
      res_status <= div_data[plet_pkg::DIV_STAGES].status;
    end
  end

  assign rsp.valid  = res_valid;
  assign rsp.level  = res_level;
  assign rsp.status = res_status;

`ifndef ASSERT_OFF
  // The dividend must leave a quotient that fits: the seeded remainder is below den.
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    div_valid[0] |-> div_data[0].rem < div_data[0].den)
    else $error("divider seeded with remainder not below divisor");

  // After the last stage the remainder is a true remainder.
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    div_valid[plet_pkg::DIV_STAGES] |->
      div_data[plet_pkg::DIV_STAGES].rem < div_data[plet_pkg::DIV_STAGES].den)
    else $error("divider remainder not below divisor at exit");

  // Error results carry a zero level.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != plet_pkg::ST_OK) |-> rsp.level == '0)
    else $error("error result with nonzero level");

  // No envelope value exceeds full scale.
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.level <= plet_pkg::ONE_Q15)
    else $error("level above full scale");
`endif

endmodule

// ===== test/envelope_level_checker.sv =====
// Envelope level checker: watches the request, result and configuration channels,
// predicts each result and compares it. Depends on plet_pkg and the plet_if.sv interfaces.
`timescale 1ns / 1ps

module envelope_level_checker (
  input  logic clk,
  input  logic rst,
  plet_req_if  req,
  plet_rsp_if  rsp,
  plet_cfg_if  cfg,
  output int   fail_count,
  output int   awaiting
);
  import plet_pkg::*;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [ST_W-1:0]  status;
  } envelope_word_t;

  // Local copy of the register file, as last written.
  logic [MODE_W-1:0] env_mode;
  logic [N_W-1:0]    frames;
  logic [N_W-1:0]    attack;
  logic [N_W-1:0]    decay;
  logic [N_W-1:0]    rel_len;
  logic [LVL_W-1:0]  sustain;

  envelope_word_t level_queue[$];
  int             fails = 0;

  function automatic envelope_word_t envelope_at(input logic [POS_W-1:0] pos);
    envelope_word_t    w;
    longint unsigned   n, a, d, r, s, p, j, rl, lvl;
    logic [MODE_W-1:0] m;
    n = 64'(frames);
    a = 64'(attack);
    d = 64'(decay);
    r = 64'(rel_len);
    s = 64'(sustain);
    p = 64'(pos);
    m = env_mode;
    lvl = 0;
    w.status = ST_OK;
    if (n > MAX_FRAMES) n = 64'(MAX_FRAMES);
    if (s == 0) s = 64'(DEFAULT_SUSTAIN);
    if (s > ONE_Q15) s = 64'(ONE_Q15);
    if (m == MODE_ALT) m = MODE_ADSR;
    // Segment fit comes before the range check.
    case (m)
      MODE_AD:  if (a > n) w.status = ST_FIT;
      MODE_ADR: if (a + d >= n) w.status = ST_FIT;
      default:  if (a + d + r >= n) w.status = ST_FIT;
    endcase
    if (w.status == ST_OK && p >= n) w.status = ST_RANGE;
    if (w.status == ST_OK) begin
      if (p < a) begin
        lvl = p * ONE_Q15 / a;
      end else if (m == MODE_AD) begin
        lvl = (n - p) * ONE_Q15 / (n - a);
      end else if (p < a + d) begin
        j = d - (p - a);
        lvl = s + (ONE_Q15 - s) * j / d;
      end else begin
        rl = (m == MODE_ADR) ? n - a - d : r;
        if (p < n - rl) lvl = s;
        else lvl = (rl == 0) ? 0 : s * (n - p) / rl;
      end
    end
    w.level = lvl[LVL_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    envelope_word_t want;
    if (rst) begin
      env_mode = MODE_AD;
      frames   = N_W'(MAX_FRAMES);
      attack   = '0;
      decay    = '0;
      rel_len  = '0;
      sustain  = '0;
      level_queue.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MODE:    env_mode = cfg.data[MODE_W-1:0];
          CFG_FRAMES:  frames   = cfg.data;
          CFG_ATTACK:  attack   = cfg.data;
          CFG_DECAY:   decay    = cfg.data;
          CFG_RELEASE: rel_len  = cfg.data;
          CFG_SUSTAIN: sustain  = cfg.data[LVL_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) level_queue.push_back(envelope_at(req.position));
      if (rsp.valid && rsp.ready) begin
        if (level_queue.size() == 0) begin
          $error("result with nothing outstanding: level %0d status %0d",
                 rsp.level, rsp.status);
          fails++;
        end else begin
          want = level_queue.pop_front();
          if (rsp.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, rsp.level);
            fails++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fails++;
          end
        end
      end
    end
    fail_count = fails;
    awaiting   = level_queue.size();
  end

endmodule

// ===== test/piecewise_linear_envelope_table_tb.sv =====
// Testbench top for the piecewise linear envelope table: clock, reset, stimulus and verdict.
// Depends on plet_pkg, the plet_if.sv interfaces, the block and envelope_level_checker.
`timescale 1ns / 1ps

module piecewise_linear_envelope_table_tb;
  import plet_pkg::*;

  localparam int LIMIT        = 1_000_000;  // cycle budget for the whole run
  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 30;         // pipeline is 12 deep, leave margin

  // Register indexes the block has no register behind; writes must be ignored.
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_HI = CFG_IDX_W'(7);

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   fails;
  int   awaiting;
  bit   quiet = 1'b0;  // set: neither side idles

  // Stimulus-side view of the current envelope, used only to aim positions.
  int span;
  int seg_attack;
  int seg_decay;
  int seg_release;

  plet_req_if req ();
  plet_rsp_if rsp ();
  plet_cfg_if cfg ();

  piecewise_linear_envelope_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  envelope_level_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .fail_count (fails),
    .awaiting   (awaiting)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: hold ready low for random stretches, mostly short, a few long.
  initial begin
    int stall;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 99) < 25) begin
        rsp.ready <= 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        repeat (stall - 1) @(negedge clk);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Idle cycles before the next request word.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Entered and left at a falling edge; valid stays high on exit so that
  // back-to-back words never drop it in between.
  task automatic put_position(input logic [POS_W-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid    <= 1'b1;
    req.position <= pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic drain_results();
    req.valid <= 1'b0;
    wait (awaiting == 0);
    @(negedge clk);
  endtask

  // Same edge discipline as put_position; the caller lowers valid.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all six registers; call only with the pipeline empty.
  task automatic set_envelope(input logic [CFG_DATA_W-1:0] mode, input logic [CFG_DATA_W-1:0] n,
                              input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] d,
                              input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] s);
    write_reg(CFG_MODE, mode);
    write_reg(CFG_FRAMES, n);
    write_reg(CFG_ATTACK, a);
    write_reg(CFG_DECAY, d);
    write_reg(CFG_RELEASE, r);
    write_reg(CFG_SUSTAIN, s);
    if ($urandom_range(0, 7) == 0)
      write_reg($urandom_range(0, 1) ? UNUSED_REG_HI : UNUSED_REG_LO,
                CFG_DATA_W'($urandom_range(0, 131071)));
    cfg.valid <= 1'b0;
    span        = (n > MAX_FRAMES) ? MAX_FRAMES : int'(n);
    seg_attack  = int'(a);
    seg_decay   = int'(d);
    seg_release = int'(r);
  endtask

  // Pick a random envelope: mostly segments that fit, so the levels get exercised,
  // with a share of oversized segments for the fit error.
  task automatic random_envelope();
    logic [MODE_W-1:0]     m;
    logic [CFG_DATA_W-1:0] mode_word, n, a, d, r, s;
    int                    ne, pick;
    pick = $urandom_range(0, 9);
    m = (pick < 3) ? MODE_AD : (pick < 6) ? MODE_ADR : (pick < 9) ? MODE_ADSR : MODE_ALT;
    // Upper data bits of the mode write carry junk now and then.
    mode_word = ($urandom_range(0, 3) == 0) ? {15'($urandom_range(0, 32767)), m} : N_W'(m);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = N_W'($urandom_range(1, 64));
      4, 5, 6:    n = N_W'($urandom_range(65, 4096));
      7:          n = N_W'(MAX_FRAMES);
      8:          n = N_W'($urandom_range(4097, 65535));
      default:    n = N_W'($urandom_range(65537, 131071));
    endcase
    ne = (n > MAX_FRAMES) ? MAX_FRAMES : int'(n);
    if ($urandom_range(0, 9) < 8) begin
      if (m == MODE_AD) begin
        a = N_W'($urandom_range(0, ne));
        d = N_W'($urandom_range(0, 131071));
        r = N_W'($urandom_range(0, 131071));
      end else begin
        a = N_W'($urandom_range(0, ne - 1));
        d = N_W'($urandom_range(0, ne - 1 - a));
        r = (m == MODE_ADR) ? N_W'($urandom_range(0, 131071))
                            : N_W'($urandom_range(0, ne - 1 - a - d));
      end
    end else begin
      a = N_W'($urandom_range(0, 131071));
      d = N_W'($urandom_range(0, 131071));
      r = N_W'($urandom_range(0, 131071));
    end
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = N_W'(ONE_Q15);
      2:       s = N_W'($urandom_range(0, 131071));
      default: s = N_W'($urandom_range(1, 32768));
    endcase
    set_envelope(mode_word, n, a, d, r, s);
  endtask

  // Positions: mostly inside the table, some on segment edges, some anywhere.
  function automatic logic [POS_W-1:0] pick_position();
    int r, b;
    r = $urandom_range(0, 99);
    if (r < 70 && span > 0) return POS_W'($urandom_range(0, span - 1));
    if (r < 85) begin
      case ($urandom_range(0, 5))
        0:       b = 0;
        1:       b = seg_attack;
        2:       b = seg_attack + seg_decay;
        3:       b = span - seg_release;
        4:       b = span - 1;
        default: b = span;
      endcase
      b = b + int'($urandom_range(0, 2)) - 1;
      if (b < 0) b = 0;
      if (b > 65535) b = 65535;
      return POS_W'(b);
    end
    return POS_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int sent, count;
    req.valid    = 1'b0;
    req.position = '0;
    cfg.valid    = 1'b0;
    cfg.index    = '0;
    cfg.data     = '0;
    rst          = 1'b1;
    span         = MAX_FRAMES;
    seg_attack   = 0;
    seg_decay    = 0;
    seg_release  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register defaults: no attack, whole table is decay; both ends of the position field.
    put_position(16'd0);
    put_position(16'd65535);
    put_position(16'd32768);

    // Attack fills the whole table; the position just past it is out of range.
    drain_results();
    set_envelope(N_W'(MODE_AD), 100, 100, 0, 0, 0);
    put_position(16'd0);
    put_position(16'd99);
    put_position(16'd100);

    // Attack longer than the table.
    drain_results();
    set_envelope(N_W'(MODE_AD), 10, 11, 0, 0, 0);
    put_position(16'd0);

    // Attack plus decay exactly fills the table: still a fit error for this mode.
    drain_results();
    set_envelope(N_W'(MODE_ADR), 20, 5, 15, 0, 0);
    put_position(16'd3);

    // Default sustain level; pause mid-stream until the pipeline is empty.
    drain_results();
    set_envelope(N_W'(MODE_ADR), 40, 5, 10, 7, 0);
    put_position(16'd2);
    put_position(16'd5);
    put_position(16'd10);
    drain_results();
    put_position(16'd15);
    put_position(16'd39);
    put_position(16'd40);

    // Spare mode code, oversized frame count and sustain, both saturate.
    drain_results();
    set_envelope(N_W'(MODE_ALT), 17'h1FFFF, 1000, 2000, 3000, 17'h1FFFF);
    put_position(16'd0);
    put_position(16'd5000);
    put_position(16'd64000);
    put_position(16'd65535);

    // Empty table: every position is out of range.
    drain_results();
    set_envelope(N_W'(MODE_AD), 0, 0, 0, 0, 32768);
    put_position(16'd0);

    // Attack, decay and release exactly fill the table: a fit error for this mode; poke the unused register slots too.
    drain_results();
    set_envelope(N_W'(MODE_ADSR), 60, 10, 10, 40, 16384);
    @(negedge clk);
    write_reg(UNUSED_REG_LO, 17'h1FFFF);
    write_reg(UNUSED_REG_HI, 17'h0AAAA);
    cfg.valid <= 1'b0;
    put_position(16'd1);

    // Random envelopes, each followed by a burst of positions.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      quiet = ($urandom_range(0, 4) == 0);
      random_envelope();
      count = $urandom_range(20, 80);
      repeat (count) begin
        put_position(pick_position());
        sent++;
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
